// ===== rtl/core/morse_keyer_segment_generator_core_assert.svh =====
// Assertion macros shared by the keyer core modules.
// Each macro expects clk and rst_n in scope.
`ifndef MORSE_KEYER_SEGMENT_GENERATOR_CORE_ASSERT_SVH
`define MORSE_KEYER_SEGMENT_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent
`define MKSG_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define MKSG_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("assertion failed");

`else

`define MKSG_ASSERT_NOW(lbl, ant, con)
`define MKSG_ASSERT_NEXT(lbl, ant, con)

`endif

`endif

// ===== rtl/core/mksg_pkg.sv =====
`timescale 1ns / 1ps

package mksg_pkg;

    // Dit length limits and reset value (ms)
    localparam logic [7:0] DIT_MIN   = 8'd40;
    localparam logic [7:0] DIT_MAX   = 8'd150;
    localparam logic [7:0] DIT_RESET = 8'd60;

    // Multiples of a dit
    localparam logic [14:0] DAH_DITS      = 15'd3;
    localparam logic [14:0] CHAR_GAP_DITS = 15'd5;
    localparam logic [14:0] WORD_GAP_DITS = 15'd7;

    localparam logic [5:0] LETTER_COUNT = 6'd26;

    // Operation codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_LONG = 1'b1;

    // Symbol counts, A..Z then 0..9
    localparam logic [2:0] SYM_LEN [0:35] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };

    // Symbols, first in bit 0; a set bit is a dah
    localparam logic [4:0] SYM_BITS [0:35] = '{
        5'h02, 5'h01, 5'h05, 5'h01, 5'h00, 5'h04, 5'h03, 5'h00, 5'h00, 5'h0E,
        5'h0A, 5'h02, 5'h03, 5'h01, 5'h07, 5'h06, 5'h0B, 5'h02, 5'h00, 5'h01,
        5'h04, 5'h08, 5'h06, 5'h09, 5'h0D, 5'h03,
        5'h1F, 5'h1E, 5'h1C, 5'h18, 5'h10, 5'h00, 5'h01, 5'h03, 5'h07, 5'h0F
    };

    // Classified item passed from front to back; n_sym of zero marks a
    // character with no Morse code
    typedef struct packed {
        logic        is_long;
        logic [2:0]  n_sym;
        logic [4:0]  sym_bits;
        logic        eom;
        logic [14:0] long_ms;
    } mksg_desc_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic       valid;
        mksg_desc_t desc;
    } mksg_head_t;

endpackage

// ===== rtl/core/mksg_front.sv =====
`timescale 1ns / 1ps

module mksg_front
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [7:0]        char_code,
    input  logic              end_of_message,
    input  logic [14:0]       long_ms,
    input  logic              q_full,
    output logic              push,
    output mksg_pkg::mksg_desc_t desc
);

    logic [7:0] ch_up;
    logic       is_letter;
    logic       is_digit;
    logic [5:0] pos;

    // Fold case and find the table position
    always_comb
    begin
        ch_up = char_code;
        if (char_code inside {[8'h61:8'h7A]})
        begin
            ch_up = char_code - 8'd32;
        end
        is_letter = ch_up inside {[8'h41:8'h5A]};
        is_digit  = ch_up inside {[8'h30:8'h39]};
        pos       = '0;
        if (is_letter)
        begin
            pos = 6'(ch_up - 8'h41);
        end
        else if (is_digit)
        begin
            pos = 6'(ch_up - 8'h30) + mksg_pkg::LETTER_COUNT;
        end
    end

    // Build the descriptor
    always_comb
    begin
        desc.is_long  = (operation == mksg_pkg::OP_LONG);
        desc.eom      = end_of_message;
        desc.long_ms  = long_ms;
        desc.n_sym    = '0;
        desc.sym_bits = '0;
        if (is_letter || is_digit)
        begin
            desc.n_sym    = mksg_pkg::SYM_LEN[pos];
            desc.sym_bits = mksg_pkg::SYM_BITS[pos];
        end
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

endmodule

// ===== rtl/core/mksg_queue.sv =====
`timescale 1ns / 1ps

module mksg_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mksg_pkg::mksg_desc_t push_desc,
    input  logic                 pop,
    output logic                 full,
    output mksg_pkg::mksg_head_t head
);

    `include "morse_keyer_segment_generator_core_assert.svh"

    mksg_pkg::mksg_desc_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign full       = cnt_reg[1];
    assign head.valid = (cnt_reg != 2'd0);
    assign head.desc  = mem_reg[rd_ptr_reg];

    `MKSG_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= 2'd2)
    `MKSG_ASSERT_NOW(a_pop_nonempty, pop, cnt_reg != 2'd0)
    `MKSG_ASSERT_NEXT(a_push_counts, push && !pop, cnt_reg != 2'd0)

endmodule

// ===== rtl/core/mksg_back.sv =====
`timescale 1ns / 1ps

module mksg_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           dit,
    input  mksg_pkg::mksg_head_t head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 key_down,
    output logic [14:0]          duration_ms,
    output logic                 last
);

    `include "morse_keyer_segment_generator_core_assert.svh"

    logic [3:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic        key_down_reg;
    logic [14:0] duration_reg;
    logic        last_reg;

    logic [14:0] d1, d3, d5, d7;
    logic [3:0]  body;
    logic        load;
    logic        seg_down;
    logic [14:0] seg_ms;
    logic        seg_last;

    // Dit multiples
    always_comb
    begin
        d1 = {7'd0, dit};
        d3 = d1 * mksg_pkg::DAH_DITS;
        d5 = d1 * mksg_pkg::CHAR_GAP_DITS;
        d7 = d1 * mksg_pkg::WORD_GAP_DITS;
    end

    // Segment at the current step of the head item
    always_comb
    begin
        body     = (head.desc.n_sym == 3'd0) ? 4'd1 : {head.desc.n_sym, 1'b0};
        seg_down = 1'b0;
        seg_ms   = d7;
        seg_last = 1'b1;
        if (head.desc.is_long)
        begin
            if (idx_reg == 4'd0)
            begin
                seg_down = 1'b1;
                seg_ms   = head.desc.long_ms;
                seg_last = 1'b0;
            end
        end
        else if (idx_reg < body)
        begin
            seg_last = 1'b0;
            if (head.desc.n_sym == 3'd0)
            begin
                seg_ms = d5;
            end
            else if (!idx_reg[0])
            begin
                seg_down = 1'b1;
                seg_ms   = head.desc.sym_bits[idx_reg[3:1]] ? d3 : d1;
            end
            else
            begin
                seg_ms = d1;
            end
        end
        else if (idx_reg == body)
        begin
            seg_ms   = d5;
            seg_last = !head.desc.eom;
        end
    end

    // Step and output register control
    always_comb
    begin
        load           = head.valid && (!out_valid_reg || !out_stall);
        pop            = load && seg_last;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            idx_next       = seg_last ? 4'd0 : idx_reg + 4'd1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_down_reg <= seg_down;
            duration_reg <= seg_ms;
            last_reg     <= seg_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign key_down    = key_down_reg;
    assign duration_ms = duration_reg;
    assign last        = last_reg;

    `MKSG_ASSERT_NOW(a_idx_bound, 1'b1, idx_reg <= 4'd11)
    `MKSG_ASSERT_NOW(a_long_steps, head.valid && head.desc.is_long, idx_reg <= 4'd1)
    `MKSG_ASSERT_NEXT(a_pop_restarts, pop, idx_reg == 4'd0)

endmodule

// ===== rtl/core/morse_keyer_segment_generator_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     operation, char_code, end_of_message, long_ms
// result    out        out_valid / out_stall   key_down, duration_ms, last
// config    in         cfg_wr_en               cfg_wr_data (dit length, clamped 40..150)
//
// The back end emits one segment per cycle while the queue holds an item and
// out_stall is low; an item has 2 segments for a long signal, 2 to 12 for a character.
// The front classifies in the transfer cycle and a two-entry queue decouples
// it; an item's first segment goes through the queue, then the output register.
// Reset sets the dit length to 60 ms and empties the queue and output stage.
// in_stall rises only while the queue is full; out_stall holds the output
// register and stops the back end, blocking new transfers once the queue fills.

module morse_keyer_segment_generator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  char_code,
    input  logic        end_of_message,
    input  logic [14:0] long_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        key_down,
    output logic [14:0] duration_ms,
    output logic        last
);

    `include "morse_keyer_segment_generator_core_assert.svh"

    logic [7:0]           dit_reg, dit_next;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    mksg_pkg::mksg_desc_t desc;
    mksg_pkg::mksg_head_t head;

    // Dit length register with clamping
    always_comb
    begin
        dit_next = dit_reg;
        if (cfg_wr_en)
        begin
            if (cfg_wr_data < mksg_pkg::DIT_MIN)
            begin
                dit_next = mksg_pkg::DIT_MIN;
            end
            else if (cfg_wr_data > mksg_pkg::DIT_MAX)
            begin
                dit_next = mksg_pkg::DIT_MAX;
            end
            else
            begin
                dit_next = cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dit_reg <= mksg_pkg::DIT_RESET;
        end
        else
        begin
            dit_reg <= dit_next;
        end
    end

    mksg_front u_front
    (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .char_code      (char_code),
        .end_of_message (end_of_message),
        .long_ms        (long_ms),
        .q_full         (q_full),
        .push           (push),
        .desc           (desc)
    );

    mksg_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (desc),
        .pop       (pop),
        .full      (q_full),
        .head      (head)
    );

    mksg_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .dit         (dit_reg),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .key_down    (key_down),
        .duration_ms (duration_ms),
        .last        (last)
    );

    `MKSG_ASSERT_NOW(a_dit_range, 1'b1, dit_reg >= mksg_pkg::DIT_MIN && dit_reg <= mksg_pkg::DIT_MAX)

endmodule

// ===== sim/keyer_segment_check.sv =====
`timescale 1ns / 1ps

module keyer_segment_check
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  char_code,
    input  logic        end_of_message,
    input  logic [14:0] long_ms,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        key_down,
    input  logic [14:0] duration_ms,
    input  logic        last,
    output int          pending,
    output int          mismatches
);

    // Dit length bounds and timing in dit units
    localparam int DIT_FLOOR      = 40;
    localparam int DIT_CEIL       = 150;
    localparam int DIT_AT_RESET   = 60;
    localparam int DAH_UNITS      = 3;
    localparam int CHAR_GAP_UNITS = 5;
    localparam int WORD_GAP_UNITS = 7;
    localparam int ALPHA_COUNT    = 26;

    typedef struct packed {
        logic        key_down;
        logic [14:0] duration_ms;
        logic        last;
    } keyer_segment_t;

    keyer_segment_t expected_segments [$];
    logic [7:0]     dit_ms = 8'd60;
    int             mismatch_total = 0;

    // Morse patterns, A..Z then 0..9; K is keyed as dit dah dit here
    string morse_table [0:35];

    initial
    begin
        morse_table = '{
            ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
            ".-.", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
            "..-", "...-", ".--", "-..-", "-.--", "--..",
            "-----", ".----", "..---", "...--", "....-", ".....", "-....", "--...",
            "---..", "----."
        };
    end

    // One line per mismatch
    task automatic report_mismatch(input string msg);
        $display("[%0t] keyer mismatch: %s", $realtime, msg);
        mismatch_total++;
    endtask

    function automatic void add_segment(input logic down, input logic [14:0] ms);
        keyer_segment_t seg;
        seg.key_down    = down;
        seg.duration_ms = ms;
        seg.last        = 1'b0;
        expected_segments.push_back(seg);
    endfunction

    // Expected key segments for one accepted item
    function automatic void predict_segments(input logic op, input logic [7:0] ch,
                                             input logic eom, input logic [14:0] lms);
        logic [14:0]    dit;
        logic [7:0]     c;
        int             idx;
        string          pattern;
        keyer_segment_t tail;
        dit = 15'(dit_ms);
        if (op == mksg_pkg::OP_LONG)
        begin
            add_segment(1'b1, lms);
            add_segment(1'b0, 15'(dit * WORD_GAP_UNITS));
        end
        else
        begin
            c   = ch;
            idx = -1;
            // fold lower case
            if (c >= 8'h61 && c <= 8'h7A)
                c = c - 8'd32;
            if (c >= 8'h41 && c <= 8'h5A)
                idx = int'(c) - 8'h41;
            else if (c >= 8'h30 && c <= 8'h39)
                idx = int'(c) - 8'h30 + ALPHA_COUNT;
            if (idx >= 0)
            begin
                pattern = morse_table[idx];
                for (int i = 0; i < pattern.len(); i++)
                begin
                    add_segment(1'b1, (pattern[i] == "-") ? 15'(dit * DAH_UNITS) : dit);
                    add_segment(1'b0, dit);
                end
            end
            else
                add_segment(1'b0, 15'(dit * CHAR_GAP_UNITS));   // no code: silent slot
            add_segment(1'b0, 15'(dit * CHAR_GAP_UNITS));
            if (eom)
                add_segment(1'b0, 15'(dit * WORD_GAP_UNITS));
        end
        tail      = expected_segments.pop_back();
        tail.last = 1'b1;
        expected_segments.push_back(tail);
    endfunction

    // Watch both channels and the dit register write
    always @(posedge clk or negedge rst_n)
    begin : watch
        keyer_segment_t want;
        if (!rst_n)
        begin
            dit_ms = 8'(DIT_AT_RESET);
            expected_segments.delete();
            pending    <= 0;
            mismatches <= mismatch_total;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_wr_data < DIT_FLOOR)
                    dit_ms = 8'(DIT_FLOOR);
                else if (cfg_wr_data > DIT_CEIL)
                    dit_ms = 8'(DIT_CEIL);
                else
                    dit_ms = cfg_wr_data;
            end

            // result transfer against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_segments.size() == 0)
                    report_mismatch($sformatf("unexpected segment key_down=%0b duration=%0d last=%0b",
                                              key_down, duration_ms, last));
                else
                begin
                    want = expected_segments.pop_front();
                    if (key_down !== want.key_down)
                        report_mismatch($sformatf("key_down %0b, want %0b",
                                                  key_down, want.key_down));
                    if (duration_ms !== want.duration_ms)
                        report_mismatch($sformatf("duration_ms %0d, want %0d",
                                                  duration_ms, want.duration_ms));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
                end
            end

            // input transfer
            if (in_valid && !in_stall)
                predict_segments(operation, char_code, end_of_message, long_ms);

            pending    <= expected_segments.size();
            mismatches <= mismatch_total;
        end
    end

endmodule

// ===== sim/morse_keyer_segment_generator_core_test.sv =====
`timescale 1ns / 1ps

module morse_keyer_segment_generator_core_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 18;
    localparam int PHASE_COUNT  = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [7:0]  cfg_wr_data    = 8'd0;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic        operation      = mksg_pkg::OP_CHAR;
    logic [7:0]  char_code      = 8'd0;
    logic        end_of_message = 1'b0;
    logic [14:0] long_ms        = 15'd0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic        key_down;
    logic [14:0] duration_ms;
    logic        last;

    int pending;
    int mismatches;
    int cycle_count  = 0;
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;

    // Dit length per phase; the random slot is filled at run time
    logic [7:0] dit_settings [0:7] = '{8'd150, 8'd0, 8'd40, 8'd255,
                                       8'd39, 8'd151, 8'd0, 8'd41};

    // Directed characters: both cases, digits, range edges, non-letters
    logic [7:0] directed_chars [0:16] = '{
        8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39, 8'h45, 8'h54,
        8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2F, 8'h3A, 8'h00, 8'h80, 8'hFF
    };

    morse_keyer_segment_generator_core uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .char_code      (char_code),
        .end_of_message (end_of_message),
        .long_ms        (long_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .key_down       (key_down),
        .duration_ms    (duration_ms),
        .last           (last)
    );

    keyer_segment_check segment_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .char_code      (char_code),
        .end_of_message (end_of_message),
        .long_ms        (long_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .key_down       (key_down),
        .duration_ms    (duration_ms),
        .last           (last),
        .pending        (pending),
        .mismatches     (mismatches)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("morse_keyer_segment_generator_core verification failed");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request
    always
    begin
        @(posedge clk);
        if (hold_request)
        begin
            hold_request = 1'b0;
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            out_stall <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clk);
            out_stall <= 1'b0;
        end
    end

    // Offer one item and hold it until the transfer, then maybe idle
    task automatic send_item(input logic op, input logic [7:0] ch,
                             input logic eom, input logic [14:0] lms);
        in_valid       <= 1'b1;
        operation      <= op;
        char_code      <= ch;
        end_of_message <= eom;
        long_ms        <= lms;
        do
            @(posedge clk);
        while (in_stall);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Stop offering and wait for every expected segment
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic        op;
        logic [7:0]  ch;
        logic        eom;
        logic [14:0] lms;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset dit length
        for (int i = 0; i < 17; i++)
            send_item(mksg_pkg::OP_CHAR, directed_chars[i], 1'b0,
                      (i % 2 == 0) ? 15'h7FFF : 15'h0000);
        send_item(mksg_pkg::OP_CHAR, 8'h30, 1'b1, 15'd0);      // longest: five dahs and word gap
        send_item(mksg_pkg::OP_CHAR, 8'h20, 1'b1, 15'd0);      // no code with word gap
        send_item(mksg_pkg::OP_CHAR, 8'h65, 1'b1, 15'h7FFF);
        send_item(mksg_pkg::OP_LONG, 8'h41, 1'b0, 15'd0);      // zero-length carrier
        send_item(mksg_pkg::OP_LONG, 8'hFF, 1'b1, 15'h7FFF);
        send_item(mksg_pkg::OP_LONG, 8'h00, 1'b1, 15'd1);
        drain();

        // Random phases, one dit length each
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 1)
                hold_request = 1'b1;
            if (p == PHASE_COUNT - 1)
                quiet = 1'b1;
            if (p == 6)
                dit_settings[p] = 8'($urandom);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= dit_settings[p];
            @(posedge clk);
            cfg_wr_en   <= 1'b0;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                op  = ($urandom_range(0, 99) < 15) ? mksg_pkg::OP_LONG : mksg_pkg::OP_CHAR;
                lms = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 40))
                                                  : 15'($urandom);
                eom = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 3))
                    0:       ch = 8'(8'h41 + $urandom_range(0, 25));
                    1:       ch = 8'(8'h61 + $urandom_range(0, 25));
                    2:       ch = 8'(8'h30 + $urandom_range(0, 9));
                    default: ch = 8'($urandom);
                endcase
                send_item(op, ch, eom, lms);
            end
            drain();
        end

        if (mismatches == 0)
            $display("morse_keyer_segment_generator_core verification clean");
        else
            $display("morse_keyer_segment_generator_core verification failed");
        $finish;
    end

endmodule
